### rtl/rsc_pkg.sv
`timescale 1ns / 1ps

package rsc_pkg;

	localparam int unsigned DATA_W   = 32;
	localparam int unsigned COUNT_W  = 5;

	typedef logic [2:0] cmd_t;
	typedef logic [2:0] status_t;
	typedef logic [1:0] alu_op_t;

	localparam cmd_t CMD_PUSH  = 3'd0;
	localparam cmd_t CMD_ADD   = 3'd1;
	localparam cmd_t CMD_SUB   = 3'd2;
	localparam cmd_t CMD_MUL   = 3'd3;
	localparam cmd_t CMD_DIV   = 3'd4;
	localparam cmd_t CMD_PEEK  = 3'd5;
	localparam cmd_t CMD_CLEAR = 3'd6;
	localparam cmd_t CMD_QUIT  = 3'd7;

	localparam status_t ST_OK        = 3'd0;
	localparam status_t ST_EMPTY     = 3'd1;
	localparam status_t ST_UNDERFLOW = 3'd2;
	localparam status_t ST_OVERFLOW  = 3'd3;
	localparam status_t ST_DIVZERO   = 3'd4;
	localparam status_t ST_SATURATED = 3'd5;
	localparam status_t ST_HALTED    = 3'd6;

	localparam alu_op_t OP_ADD = 2'd0;
	localparam alu_op_t OP_SUB = 2'd1;
	localparam alu_op_t OP_MUL = 2'd2;
	localparam alu_op_t OP_DIV = 2'd3;

	typedef struct packed {
		logic    start;
		alu_op_t op;
	} alu_req_t;

	typedef struct packed {
		logic done;
		logic sat;
	} alu_rsp_t;

endpackage

### rtl/rsc_in_if.sv
`timescale 1ns / 1ps

interface rsc_in_if;
	logic                valid;
	logic                ready;
	rsc_pkg::cmd_t       cmd;
	logic signed [31:0]  operand;

	modport source (output valid, output cmd, output operand, input ready);
	modport sink   (input valid, input cmd, input operand, output ready);
endinterface

### rtl/rsc_out_if.sv
`timescale 1ns / 1ps

interface rsc_out_if;
	logic                valid;
	logic                ready;
	rsc_pkg::status_t    status;
	logic signed [31:0]  top_value;
	logic                top_valid;
	logic [4:0]          stack_count;

	modport source (output valid, output status, output top_value, output top_valid,
		output stack_count, input ready);
	modport sink   (input valid, input status, input top_value, input top_valid,
		input stack_count, output ready);
endinterface

### rtl/rsc_ram.sv
`timescale 1ns / 1ps

module rsc_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

### rtl/rsc_alu.sv
`timescale 1ns / 1ps

module rsc_alu (
	input  logic               clk,
	input  logic               arst_n,
	input  rsc_pkg::alu_req_t  req,
	input  logic signed [31:0] x,
	input  logic signed [31:0] y,
	output rsc_pkg::alu_rsp_t  rsp,
	output logic signed [31:0] result
);
	import rsc_pkg::*;

	localparam logic [2:0] A_IDLE = 3'd0;
	localparam logic [2:0] A_MRND = 3'd1;
	localparam logic [2:0] A_DIV  = 3'd2;
	localparam logic [2:0] A_DRND = 3'd3;
	localparam logic [2:0] A_DNEG = 3'd4;
	localparam logic [2:0] A_CLIP = 3'd5;

	localparam int unsigned NUM_W = 48;
	localparam logic [5:0]  DIV_STEPS = 6'd48;

	logic [2:0]         state_q;
	logic signed [63:0] acc_q;
	logic [NUM_W-1:0]   num_q;
	logic [31:0]        rem_q;
	logic [31:0]        den_q;
	logic               neg_q;
	logic [5:0]         cnt_q;
	logic signed [31:0] result_q;
	logic               sat_q;
	logic               done_q;

	logic signed [63:0] prod;
	logic [31:0]        abs_x;
	logic [31:0]        abs_y;
	logic [32:0]        trial;
	logic [33:0]        diff;
	logic               ge;
	logic [31:0]        rem_next;
	logic               round_up;
	logic [NUM_W:0]     q_rnd;
	logic               over;
	logic               under;

	assign prod  = y * x;
	assign abs_x = x[31] ? 32'(-x) : 32'(x);
	assign abs_y = y[31] ? 32'(-y) : 32'(y);

	// restoring divide, one quotient bit per cycle
	assign trial    = {rem_q, num_q[NUM_W-1]};
	assign diff     = {1'b0, trial} - {2'b00, den_q};
	assign ge       = ~diff[33];
	assign rem_next = ge ? diff[31:0] : trial[31:0];

	// round half away from zero on the magnitude
	assign round_up = {rem_q, 1'b0} >= {1'b0, den_q};
	assign q_rnd    = {1'b0, num_q} + {{NUM_W{1'b0}}, round_up};

	assign over  = ~acc_q[63] & (|acc_q[62:31]);
	assign under = acc_q[63] & ~(&acc_q[62:31]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= A_IDLE;
			done_q  <= 1'b0;
			cnt_q   <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				A_IDLE: begin
					if (req.start) begin
						case (req.op)
							OP_ADD: begin
								acc_q   <= {{32{y[31]}}, y} + {{32{x[31]}}, x};
								state_q <= A_CLIP;
							end
							OP_SUB: begin
								acc_q   <= {{32{y[31]}}, y} - {{32{x[31]}}, x};
								state_q <= A_CLIP;
							end
							OP_MUL: begin
								acc_q   <= prod;
								state_q <= A_MRND;
							end
							default: begin
								num_q   <= {abs_y, 16'h0000};
								den_q   <= abs_x;
								rem_q   <= '0;
								neg_q   <= x[31] ^ y[31];
								cnt_q   <= DIV_STEPS;
								state_q <= A_DIV;
							end
						endcase
					end
				end
				A_MRND: begin
					acc_q   <= (acc_q + 64'sd32768) >>> 16;
					state_q <= A_CLIP;
				end
				A_DIV: begin
					num_q <= {num_q[NUM_W-2:0], ge};
					rem_q <= rem_next;
					cnt_q <= cnt_q - 6'd1;
					if (cnt_q == 6'd1) begin
						state_q <= A_DRND;
					end
				end
				A_DRND: begin
					acc_q   <= {{(64-NUM_W-1){1'b0}}, q_rnd};
					state_q <= A_DNEG;
				end
				A_DNEG: begin
					if (neg_q) begin
						acc_q <= -acc_q;
					end
					state_q <= A_CLIP;
				end
				A_CLIP: begin
					if (over) begin
						result_q <= 32'sh7fffffff;
					end else if (under) begin
						result_q <= 32'sh80000000;
					end else begin
						result_q <= acc_q[31:0];
					end
					sat_q   <= over | under;
					done_q  <= 1'b1;
					state_q <= A_IDLE;
				end
				default: begin
					state_q <= A_IDLE;
				end
			endcase
		end
	end

	assign rsp.done = done_q;
	assign rsp.sat  = sat_q;
	assign result   = result_q;

endmodule

### rtl/rpn_stack_calculator.sv
`timescale 1ns / 1ps

// channel  | modport | payload
// ---------+---------+-------------------------------------------------
// in_ch    | sink    | cmd[2:0], operand[31:0] (Q16.16)
// out_ch   | source  | status[2:0], top_value[31:0], top_valid, stack_count[4:0]
//
// One transaction in, one transaction out; ready on in_ch only between commands.
// Push, peek, clear, quit and rejected commands: S_EXEC, then S_RESP registers the result.
// Arithmetic adds S_READ (stack RAM read) and S_ALU, where mul adds a rounding step and the divider
// retires one of 48 quotient bits per cycle. Next command accepted only after S_RESP registers.
// Reset clears count and halt flag; stack RAM contents are not cleared.
// A stalled out_ch holds the result and blocks the next command.

module rpn_stack_calculator #(
	parameter int unsigned STACK_DEPTH = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	rsc_in_if.sink           in_ch,
	rsc_out_if.source        out_ch
);
	import rsc_pkg::*;

	localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
	localparam int unsigned AW = $clog2(STACK_DEPTH);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_EXEC = 3'd1;
	localparam logic [2:0] S_READ = 3'd2;
	localparam logic [2:0] S_ALU  = 3'd3;
	localparam logic [2:0] S_RESP = 3'd4;

	logic [2:0]         state_q;
	logic [CW-1:0]      count_q;
	logic               halted_q;
	cmd_t               cmd_q;
	logic signed [31:0] operand_q;
	logic signed [31:0] top_q;
	status_t            status_q;

	logic               out_valid_q;
	status_t            out_status_q;
	logic signed [31:0] out_top_q;
	logic               out_top_valid_q;
	logic [4:0]         out_count_q;

	logic               wr_en;
	logic [AW-1:0]      wr_addr;
	logic [31:0]        wr_data;
	logic               rd_en;
	logic [CW-1:0]      count_m2;
	logic [31:0]        rd_data;

	alu_req_t           alu_req;
	alu_rsp_t           alu_rsp;
	logic signed [31:0] alu_result;
	alu_op_t            alu_op;

	logic               is_arith;
	logic               can_load;
	logic [CW+4:0]      count_ext;

	assign count_m2 = count_q - CW'(2);
	assign is_arith = (cmd_q == CMD_ADD) || (cmd_q == CMD_SUB) ||
		(cmd_q == CMD_MUL) || (cmd_q == CMD_DIV);

	always_comb begin
		case (cmd_q)
			CMD_ADD: alu_op = OP_ADD;
			CMD_SUB: alu_op = OP_SUB;
			CMD_MUL: alu_op = OP_MUL;
			default: alu_op = OP_DIV;
		endcase
	end

	// stack RAM: push writes at count, arithmetic reads/writes second-from-top
	assign rd_en = (state_q == S_EXEC) && !halted_q && is_arith;

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = count_q[AW-1:0];
		wr_data = operand_q;
		if (state_q == S_EXEC && !halted_q && cmd_q == CMD_PUSH &&
			count_q != CW'(STACK_DEPTH)) begin
			wr_en = 1'b1;
		end else if (state_q == S_ALU && alu_rsp.done) begin
			wr_en   = 1'b1;
			wr_addr = count_m2[AW-1:0];
			wr_data = alu_result;
		end
	end

	rsc_ram #(
		.WIDTH (32),
		.DEPTH (STACK_DEPTH)
	) u_stack (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (count_m2[AW-1:0]),
		.rd_data (rd_data)
	);

	assign alu_req.start = (state_q == S_READ);
	assign alu_req.op    = alu_op;

	rsc_alu u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (alu_req),
		.x      (top_q),
		.y      (rd_data),
		.rsp    (alu_rsp),
		.result (alu_result)
	);

	assign in_ch.ready = (state_q == S_IDLE);
	assign can_load    = !out_valid_q || out_ch.ready;
	assign count_ext   = {5'b00000, count_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			halted_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_ch.valid) begin
						cmd_q     <= in_ch.cmd;
						operand_q <= in_ch.operand;
						state_q   <= S_EXEC;
					end
				end
				S_EXEC: begin
					status_q <= ST_OK;
					state_q  <= S_RESP;
					if (halted_q) begin
						status_q <= ST_HALTED;
					end else begin
						case (cmd_q)
							CMD_PUSH: begin
								if (count_q == CW'(STACK_DEPTH)) begin
									status_q <= ST_OVERFLOW;
								end else begin
									top_q   <= operand_q;
									count_q <= count_q + CW'(1);
								end
							end
							CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV: begin
								if (count_q < CW'(2)) begin
									status_q <= ST_UNDERFLOW;
								end else if (cmd_q == CMD_DIV && top_q == 32'sd0) begin
									status_q <= ST_DIVZERO;
								end else begin
									state_q <= S_READ;
								end
							end
							CMD_PEEK: begin
								if (count_q == '0) begin
									status_q <= ST_EMPTY;
								end
							end
							CMD_CLEAR: begin
								count_q <= '0;
							end
							default: begin
								halted_q <= 1'b1;
							end
						endcase
					end
				end
				S_READ: begin
					state_q <= S_ALU;
				end
				S_ALU: begin
					if (alu_rsp.done) begin
						top_q    <= alu_result;
						count_q  <= count_q - CW'(1);
						status_q <= alu_rsp.sat ? ST_SATURATED : ST_OK;
						state_q  <= S_RESP;
					end
				end
				S_RESP: begin
					if (can_load) begin
						out_valid_q     <= 1'b1;
						out_status_q    <= status_q;
						out_top_q       <= (count_q != '0) ? top_q : 32'sd0;
						out_top_valid_q <= (count_q != '0);
						out_count_q     <= count_ext[4:0];
						state_q         <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_ch.valid       = out_valid_q;
	assign out_ch.status      = out_status_q;
	assign out_ch.top_value   = out_top_q;
	assign out_ch.top_valid   = out_top_valid_q;
	assign out_ch.stack_count = out_count_q;

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
	import rsc_pkg::*;

	localparam int CALC_DEPTH = 16;
	localparam int CYCLE_LIMIT = 800000;
	localparam int SETTLE_CYCLES = 80;
	localparam longint Q_MAX = 64'sh0000_0000_7FFF_FFFF;
	localparam longint Q_MIN = -64'sh0000_0000_8000_0000;

	typedef struct {
		cmd_t               cmd;
		logic signed [31:0] operand;
	} calc_cmd_t;

	typedef struct {
		status_t            status;
		logic signed [31:0] top_value;
		logic               top_valid;
		logic [4:0]         stack_count;
	} calc_result_t;

	logic clk = 1'b0;
	logic arst_n;

	rsc_in_if  in_ch ();
	rsc_out_if out_ch ();

	rpn_stack_calculator #(
		.STACK_DEPTH (CALC_DEPTH)
	) u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// predicted calculator state
	logic signed [31:0] stack_mem [CALC_DEPTH];
	int                 entry_cnt = 0;
	logic               halted = 1'b0;

	calc_cmd_t    cmd_queue[$];
	calc_result_t expected_results[$];

	int  queued_total = 0;
	int  accepted_total = 0;
	int  checked_total = 0;
	int  mismatch_count = 0;
	int  cycle_count = 0;
	int  gen_depth = 0;
	int  send_idle_pct = 0;
	int  sink_stall_pct = 0;
	int  status_hits [7];
	logic in_fire = 1'b0;

	cmd_t arith_ops [4] = '{CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV};

	function automatic calc_result_t calc_step(cmd_t c, logic signed [31:0] v);
		calc_result_t       r;
		longint             x;
		longint             y;
		longint             acc;
		longint unsigned    n;
		longint unsigned    d;
		longint unsigned    q;
		logic               clipped;
		r.status = ST_OK;
		clipped = 1'b0;
		acc = 0;
		if (halted) begin
			r.status = ST_HALTED;
		end else begin
			case (c)
			CMD_PUSH: begin
				if (entry_cnt >= CALC_DEPTH) begin
					r.status = ST_OVERFLOW;
				end else begin
					stack_mem[entry_cnt] = v;
					entry_cnt++;
				end
			end
			CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV: begin
				if (entry_cnt < 2) begin
					r.status = ST_UNDERFLOW;
				end else begin
					x = stack_mem[entry_cnt - 1];
					y = stack_mem[entry_cnt - 2];
					if (c == CMD_DIV && x == 0) begin
						r.status = ST_DIVZERO;
					end else begin
						case (c)
						CMD_ADD: acc = y + x;
						CMD_SUB: acc = y - x;
						// round half up, then floor shift
						CMD_MUL: acc = (y * x + 64'sd32768) >>> 16;
						default: begin
							// magnitude division, ties away from zero
							n = longint'(y < 0 ? -y : y) << 16;
							d = longint'(x < 0 ? -x : x);
							q = (2 * n + d) / (2 * d);
							acc = ((y < 0) != (x < 0)) ? -longint'(q) : longint'(q);
						end
						endcase
						if (acc > Q_MAX) begin
							acc = Q_MAX;
							clipped = 1'b1;
						end else if (acc < Q_MIN) begin
							acc = Q_MIN;
							clipped = 1'b1;
						end
						entry_cnt--;
						stack_mem[entry_cnt - 1] = acc[31:0];
						if (clipped)
							r.status = ST_SATURATED;
					end
				end
			end
			CMD_PEEK: begin
				if (entry_cnt == 0)
					r.status = ST_EMPTY;
			end
			CMD_CLEAR: entry_cnt = 0;
			default: halted = 1'b1;
			endcase
		end
		if (entry_cnt > 0) begin
			r.top_value = stack_mem[entry_cnt - 1];
			r.top_valid = 1'b1;
		end else begin
			r.top_value = '0;
			r.top_valid = 1'b0;
		end
		r.stack_count = 5'(entry_cnt);
		return r;
	endfunction

	function automatic logic signed [31:0] pick_operand();
		int                 ip;
		logic signed [31:0] v;
		ip = int'($urandom_range(16)) - 8;
		case ($urandom_range(9))
		0: v = 32'sh7FFF_FFFF;
		1: v = 32'sh8000_0000;
		2: v = '0;
		3, 4, 5: v = ip * 65536 + int'($urandom_range(65535));
		6, 7: v = $signed($urandom()) >>> $urandom_range(24);
		default: v = $urandom();
		endcase
		return v;
	endfunction

	task automatic queue_item(cmd_t c, logic signed [31:0] v);
		calc_cmd_t item;
		item.cmd = c;
		item.operand = v;
		cmd_queue.push_back(item);
		queued_total++;
		// rough depth tracking, only used to bias the mix
		case (c)
		CMD_PUSH: if (gen_depth < CALC_DEPTH) gen_depth++;
		CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV: if (gen_depth >= 2) gen_depth--;
		CMD_CLEAR: gen_depth = 0;
		default: ;
		endcase
	endtask

	task automatic queue_random(int n_items);
		int stop_at;
		int sel;
		stop_at = queued_total + n_items;
		while (queued_total < stop_at) begin
			sel = $urandom_range(99);
			if (gen_depth < 2 && sel < 80) begin
				queue_item(CMD_PUSH, pick_operand());
			end else if (sel < 35) begin
				queue_item(CMD_PUSH, pick_operand());
			end else if (sel < 75) begin
				queue_item(arith_ops[$urandom_range(3)], $urandom());
			end else if (sel < 85) begin
				queue_item(CMD_PEEK, $urandom());
			end else if (sel < 88) begin
				queue_item(CMD_CLEAR, $urandom());
			end else if (sel < 91) begin
				// fill to the top, then push past it
				while (gen_depth < CALC_DEPTH)
					queue_item(CMD_PUSH, pick_operand());
				repeat ($urandom_range(1, 3))
					queue_item(CMD_PUSH, pick_operand());
			end else begin
				queue_item(cmd_t'($urandom_range(CMD_CLEAR)), $urandom());
			end
		end
	endtask

	task automatic wait_drained();
		while (accepted_total != queued_total || expected_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic compare_field(string field, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			mismatch_count++;
			if (mismatch_count <= 10)
				$display("mismatch on result %0d, %s: expected %h, got %h",
					checked_total, field, want, got);
		end
	endtask

	// driver: new transaction or idle at the falling edge
	always @(negedge clk) begin : drive_blk
		calc_cmd_t next_item;
		if (arst_n) begin
			if (!in_ch.valid || in_fire) begin
				if (cmd_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					next_item = cmd_queue.pop_front();
					in_ch.valid <= 1'b1;
					in_ch.cmd <= next_item.cmd;
					in_ch.operand <= next_item.operand;
				end else begin
					in_ch.valid <= 1'b0;
				end
			end
			out_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
		end
	end

	// monitor: predict on accepted commands, check accepted results
	always @(posedge clk) begin : monitor_blk
		calc_result_t want;
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycle_count, expected_results.size());
			$display("TB_ERROR");
			$finish;
		end else begin
			in_fire <= in_ch.valid && in_ch.ready;
			if (out_ch.valid === 1'b1 && out_ch.ready) begin
				if (expected_results.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("unexpected result: status %0d top %h count %0d",
							out_ch.status, out_ch.top_value, out_ch.stack_count);
				end else begin
					want = expected_results.pop_front();
					compare_field("status", 32'(want.status), 32'(out_ch.status));
					compare_field("top_value", want.top_value, out_ch.top_value);
					compare_field("top_valid", 32'(want.top_valid), 32'(out_ch.top_valid));
					compare_field("stack_count", 32'(want.stack_count),
						32'(out_ch.stack_count));
					checked_total++;
				end
			end
			if (in_ch.valid && in_ch.ready) begin
				want = calc_step(in_ch.cmd, in_ch.operand);
				expected_results.push_back(want);
				status_hits[want.status]++;
				accepted_total++;
			end
		end
	end

	initial begin
		in_ch.valid = 1'b0;
		in_ch.cmd = CMD_PEEK;
		in_ch.operand = '0;
		out_ch.ready = 1'b0;
		arst_n = 1'b0;
		foreach (status_hits[i])
			status_hits[i] = 0;
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;

		// directed: empty stack, underflow, saturation, divide by zero, rounding
		queue_item(CMD_PEEK, 32'sh7FFF_FFFF);
		queue_item(CMD_ADD, '0);
		queue_item(CMD_PUSH, 32'sh7FFF_FFFF);
		queue_item(CMD_SUB, '0);
		queue_item(CMD_PUSH, 32'sh7FFF_FFFF);
		queue_item(CMD_ADD, '0);
		queue_item(CMD_PUSH, 32'sh8000_0000);
		queue_item(CMD_SUB, '0);
		queue_item(CMD_PUSH, 32'sh8000_0000);
		queue_item(CMD_MUL, '0);
		queue_item(CMD_PUSH, '0);
		queue_item(CMD_DIV, '1);
		queue_item(CMD_CLEAR, '0);
		queue_item(CMD_PUSH, 32'sh0003_0000);
		queue_item(CMD_PUSH, 32'shFFFE_0000);
		queue_item(CMD_DIV, '0);
		queue_item(CMD_PUSH, 32'sh0000_0001);
		queue_item(CMD_MUL, '0);
		queue_item(CMD_PUSH, 32'sh0000_8000);
		queue_item(CMD_MUL, '0);
		queue_item(CMD_PUSH, 32'sh8000_0000);
		queue_item(CMD_PUSH, 32'shFFFF_0000);
		queue_item(CMD_DIV, '0);
		queue_item(CMD_PEEK, '1);
		queue_item(CMD_CLEAR, '1);
		gen_depth = 0;
		wait_drained();

		// flow-control phases: none, sender idle, receiver stall, both
		send_idle_pct = 0;
		sink_stall_pct = 0;
		queue_random(400);
		wait_drained();
		send_idle_pct = 74;
		sink_stall_pct = 0;
		queue_random(400);
		wait_drained();
		send_idle_pct = 0;
		sink_stall_pct = 74;
		queue_random(400);
		wait_drained();
		send_idle_pct = 31;
		sink_stall_pct = 31;
		queue_random(400);

		// quit last: nothing after it can leave the halted state
		queue_item(CMD_PUSH, pick_operand());
		queue_item(CMD_QUIT, $urandom());
		queue_item(CMD_PUSH, pick_operand());
		queue_item(CMD_PEEK, $urandom());
		queue_item(CMD_ADD, $urandom());
		queue_item(CMD_CLEAR, $urandom());
		queue_item(CMD_QUIT, $urandom());
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("%0d commands driven, %0d results checked, %0d mismatches",
			accepted_total, checked_total, mismatch_count);
		$display("outcomes: ok %0d empty %0d underflow %0d overflow %0d divzero %0d sat %0d halt %0d",
			status_hits[ST_OK], status_hits[ST_EMPTY], status_hits[ST_UNDERFLOW],
			status_hits[ST_OVERFLOW], status_hits[ST_DIVZERO],
			status_hits[ST_SATURATED], status_hits[ST_HALTED]);
		if (mismatch_count == 0 && expected_results.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
